### hw/rtl/mfbp_pkg.sv
package mfbp_pkg;

    localparam int MAX_FIELD_BITS = 64;
    localparam int WORD_BITS      = 64;
    localparam int WORD_BYTES     = WORD_BITS / 8;
    localparam int WIDTH_W        = 7;
    localparam int COUNT_W        = 6;
    localparam int BYTES_W        = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;
    localparam int QCNT_W         = QPTR_W + 1;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // One classified item: value left aligned at the top, width saturated
    typedef struct packed {
        logic                  flush;
        logic [WORD_BITS-1:0]  bits;
        logic [WIDTH_W-1:0]    width;
    } mfbp_entry_t;

endpackage

### hw/rtl/mfbp_front.sv
module mfbp_front
    import mfbp_pkg::*;
(
    input  logic                 in_valid,
    input  logic                 in_func,
    input  logic [63:0]          in_value,
    input  logic [WIDTH_W-1:0]   in_width,
    input  logic                 q_full,
    output logic                 in_ready,
    output logic                 push,
    output mfbp_entry_t          push_entry
);

    logic [WIDTH_W-1:0] width_sat;
    logic [WIDTH_W-1:0] shift_amt;
    logic               drop;

    always_comb begin
        if (in_width > WIDTH_W'(MAX_FIELD_BITS)) begin
            width_sat = WIDTH_W'(MAX_FIELD_BITS);
        end else begin
            width_sat = in_width;
        end
        // a zero width wraps the shift to zero; that append is dropped
        shift_amt = WIDTH_W'(WORD_BITS) - width_sat;
        drop      = (in_func == FUNC_APPEND) && (width_sat == '0);
    end

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready && !drop;

    // Left-align the field; the unused high bits fall off the top
    always_comb begin
        push_entry.flush = (in_func == FUNC_FLUSH);
        push_entry.bits  = in_value << shift_amt[COUNT_W-1:0];
        push_entry.width = width_sat;
    end

endmodule

### hw/rtl/mfbp_queue.sv
module mfbp_queue
    import mfbp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  mfbp_entry_t  push_entry,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output mfbp_entry_t  head
);

    mfbp_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg,    cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hw/rtl/mfbp_back.sv
module mfbp_back
    import mfbp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_not_empty,
    input  mfbp_entry_t  q_head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         out_last
);

    logic [WORD_BITS-1:0]   hi_reg,   hi_next;
    logic [COUNT_W-1:0]     cnt_reg,  cnt_next;
    logic [WORD_BITS-1:0]   word_reg, word_next;
    logic [BYTES_W-1:0]     left_reg, left_next;

    logic [2*WORD_BITS-1:0] merged;
    logic [WIDTH_W-1:0]     sum;
    logic [WIDTH_W-1:0]     round_up;
    logic                   emits;
    logic [WORD_BITS-1:0]   emit_word;
    logic [BYTES_W-1:0]     emit_bytes;
    logic                   emit_free;
    logic                   load;
    logic                   out_xfer;

    assign out_xfer  = out_valid && out_ready;
    assign emit_free = (left_reg == '0) || ((left_reg == BYTES_W'(1)) && out_ready);

    always_comb begin
        merged   = {hi_reg, {WORD_BITS{1'b0}}}
                 | ({q_head.bits, {WORD_BITS{1'b0}}} >> cnt_reg);
        sum      = {1'b0, cnt_reg} + q_head.width;
        round_up = {1'b0, cnt_reg} + WIDTH_W'(7);
        hi_next  = hi_reg;
        cnt_next = cnt_reg;
        emit_word  = hi_reg;
        emit_bytes = BYTES_W'(WORD_BYTES);
        if (q_head.flush) begin
            emits      = (cnt_reg != '0);
            emit_bytes = round_up[WIDTH_W-1:3];
            hi_next    = '0;
            cnt_next   = '0;
        end else begin
            emits     = sum[WIDTH_W-1];
            emit_word = merged[2*WORD_BITS-1:WORD_BITS];
            cnt_next  = sum[COUNT_W-1:0];
            if (emits) begin
                hi_next = merged[WORD_BITS-1:0];
            end else begin
                hi_next = merged[2*WORD_BITS-1:WORD_BITS];
            end
        end
        // stall only an item that needs the byte stage while it is busy
        pop  = q_not_empty && (!emits || emit_free);
        load = pop && emits;
    end

    always_comb begin
        word_next = word_reg;
        left_next = left_reg;
        if (load) begin
            word_next = emit_word;
            left_next = emit_bytes;
        end else if (out_xfer) begin
            word_next = word_reg << 8;
            left_next = left_reg - 1'b1;
        end
    end

    assign out_valid = (left_reg != '0);
    assign out_byte  = word_reg[WORD_BITS-1 -: 8];
    assign out_last  = (left_reg == BYTES_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg   <= '0;
            cnt_reg  <= '0;
            left_reg <= '0;
        end else begin
            if (pop) begin
                hi_reg  <= hi_next;
                cnt_reg <= cnt_next;
            end
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> ((left_reg == '0) || ((left_reg == BYTES_W'(1)) && out_ready)))
        else $error("byte stage loaded while busy");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_head.flush) |=> ((cnt_reg == '0) && (hi_reg == '0)))
        else $error("flush left bits behind");

    a_clean_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        ((hi_reg & ({WORD_BITS{1'b1}} >> cnt_reg)) == '0))
        else $error("bits below the held count are not zero");

endmodule

### hw/rtl/msb_first_bit_packer_unit.sv
// MSB-first bit packer.
// Input channel (s_*): one transfer per field. s_tuser selects the function:
// 0 appends the low field_width bits of field_value (width 1..64, larger
// widths act as 64, zero appends nothing), 1 flushes the held bits.
// Output channel (m_*): one byte per transfer, earliest bits in the MSB;
// m_tlast marks the final byte caused by one input item.
// A write that brings the held count to 64 or more sends 8 bytes; a flush
// sends ceil(count/8) bytes, zero padded, then empties the buffer.
// With the queue empty and the byte register free, an item is registered
// first into the 4-entry queue and then into the byte register before its
// first byte can transfer.
// Throughput: one item per cycle while items cause no bytes; the byte
// register sends one byte per cycle while m_tready is high, and a
// byte-causing item waits at the queue head while earlier bytes remain.
// When m_tready is low, a byte-causing item waits at the queue head once the
// byte register is busy; the 4-entry queue then fills and s_tready drops.
// Reset (aresetn low, synchronous) empties the queue, the bit buffer and
// the byte register; no bytes are pending afterwards.
module msb_first_bit_packer_unit
    import mfbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] field_value, [70:64] field_width, [71] zero
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    logic        q_full;
    logic        q_not_empty;
    logic        push;
    logic        pop;
    mfbp_entry_t push_entry;
    mfbp_entry_t q_head;

    mfbp_front u_front (
        .in_valid   (s_tvalid),
        .in_func    (s_tuser),
        .in_value   (s_tdata[63:0]),
        .in_width   (s_tdata[70:64]),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    mfbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    mfbp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );

endmodule
